>>> design/rss_pkg.sv
// Package for the roast session sequencer.
// Holds command, phase, mode and status codes and the input beat struct.
// No dependencies.
`timescale 1ns / 1ps

package rss_pkg;

    localparam logic [3:0] CMD_TICK     = 4'd0;
    localparam logic [3:0] CMD_START    = 4'd1;
    localparam logic [3:0] CMD_PAUSE    = 4'd2;
    localparam logic [3:0] CMD_RESUME   = 4'd3;
    localparam logic [3:0] CMD_CHARGE   = 4'd4;
    localparam logic [3:0] CMD_COOL     = 4'd5;
    localparam logic [3:0] CMD_CANCEL   = 4'd6;
    localparam logic [3:0] CMD_COMPLETE = 4'd7;
    localparam logic [3:0] CMD_ABORT    = 4'd8;
    localparam logic [3:0] CMD_MANUAL   = 4'd9;
    localparam logic [3:0] CMD_SAFETY   = 4'd10;
    localparam logic [3:0] CMD_RESTORE  = 4'd11;
    localparam logic [3:0] CMD_QUERY    = 4'd12;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_PREHEAT  = 3'd1;
    localparam logic [2:0] PH_ROASTING = 3'd2;
    localparam logic [2:0] PH_DEVELOP  = 3'd3;
    localparam logic [2:0] PH_COOLING  = 3'd4;
    localparam logic [2:0] PH_DONE     = 3'd5;
    localparam logic [2:0] PH_ABORTED  = 3'd6;

    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_PROFILE = 2'd1;
    localparam logic [1:0] MODE_MANUAL  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_STATE = 2'd1;
    localparam logic [1:0] ST_ARG   = 2'd2;

    localparam logic [1:0] SAFETY_OK = 2'd0;

    localparam int RESTORE_BITS = 32;

    typedef struct packed {
        logic [3:0]              command;
        logic [1:0]              mode_in;
        logic                    confirmed;
        logic [1:0]              safety_in;
        logic [2:0]              restore_phase;
        logic                    restore_paused;
        logic                    restore_switched;
        logic [RESTORE_BITS-1:0] restore_elapsed;
    } cmd_t;

    // handoff from the input stage to the core
    typedef struct packed {
        logic valid;
        cmd_t beat;
    } stage_t;

endpackage

>>> design/rss_if.sv
// Channel interfaces for the roast session sequencer.
// Command channel and result channel; depends on nothing.
`timescale 1ns / 1ps

interface rss_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [1:0]  mode_in;
    logic        confirmed;
    logic [1:0]  safety_in;
    logic [2:0]  restore_phase;
    logic        restore_paused;
    logic        restore_switched;
    logic [31:0] restore_elapsed;

    modport source (
        output valid, command, mode_in, confirmed, safety_in, restore_phase,
               restore_paused, restore_switched, restore_elapsed,
        input  ready
    );
    modport sink (
        input  valid, command, mode_in, confirmed, safety_in, restore_phase,
               restore_paused, restore_switched, restore_elapsed,
        output ready
    );
endinterface

interface rss_res_if #(
    parameter int ELAPSED_BITS = 32
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [2:0]              phase;
    logic                    is_paused;
    logic [1:0]              ctrl_mode;
    logic                    switch_used;
    logic [1:0]              safety_level;
    logic                    abort_pending;
    logic [ELAPSED_BITS-1:0] elapsed_count;
    logic                    heater_off;
    logic                    persist;

    modport source (
        output valid, status, phase, is_paused, ctrl_mode, switch_used,
               safety_level, abort_pending, elapsed_count, heater_off, persist,
        input  ready
    );
    modport sink (
        input  valid, status, phase, is_paused, ctrl_mode, switch_used,
               safety_level, abort_pending, elapsed_count, heater_off, persist,
        output ready
    );
endinterface

>>> design/rss_in_stage.sv
// Input register for the roast session sequencer.
// Captures one command beat; depends on rss_pkg and rss_cmd_if.
`timescale 1ns / 1ps

module rss_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    rss_cmd_if.sink         cmd,
    input  logic            take,
    output rss_pkg::stage_t stage
);
    import rss_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t beat_reg;

    assign cmd.ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.ready)
        begin
            valid_next = cmd.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            beat_reg.command          <= cmd.command;
            beat_reg.mode_in          <= cmd.mode_in;
            beat_reg.confirmed        <= cmd.confirmed;
            beat_reg.safety_in        <= cmd.safety_in;
            beat_reg.restore_phase    <= cmd.restore_phase;
            beat_reg.restore_paused   <= cmd.restore_paused;
            beat_reg.restore_switched <= cmd.restore_switched;
            beat_reg.restore_elapsed  <= cmd.restore_elapsed;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.beat  = beat_reg;

endmodule

>>> design/rss_core.sv
// Session state registers, command decode and result register.
// Depends on rss_pkg and rss_res_if.
`timescale 1ns / 1ps

module rss_core #(
    parameter int ELAPSED_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rss_pkg::stage_t stage,
    output logic            take,
    rss_res_if.source       res
);
    import rss_pkg::*;

    localparam int CMP_BITS = (ELAPSED_BITS > RESTORE_BITS) ? ELAPSED_BITS : RESTORE_BITS;
    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = {ELAPSED_BITS{1'b1}};

    logic [2:0]              phase_reg, phase_next;
    logic                    paused_reg, paused_next;
    logic [1:0]              mode_reg, mode_next;
    logic                    switched_reg, switched_next;
    logic [1:0]              safety_reg, safety_next;
    logic                    pending_abort_reg, pending_abort_next;
    logic [ELAPSED_BITS-1:0] elapsed_reg, elapsed_next;

    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              status_reg, status_next;
    logic                    heater_off_reg, heater_off_next;
    logic                    persist_reg, persist_next;

    logic                    active;
    logic                    mode_ok;
    logic [CMP_BITS-1:0]     restore_ext;
    logic [ELAPSED_BITS-1:0] restore_sat;
    cmd_t                    b;

    assign b       = stage.beat;
    assign take    = stage.valid && (!out_valid_reg || res.ready);
    assign active  = phase_reg inside {[PH_PREHEAT:PH_COOLING]};
    assign mode_ok = b.mode_in inside {MODE_PROFILE, MODE_MANUAL};

    assign restore_ext = CMP_BITS'(b.restore_elapsed);
    assign restore_sat = (restore_ext > CMP_BITS'(ELAPSED_MAX)) ? ELAPSED_MAX
                                                                 : restore_ext[ELAPSED_BITS-1:0];

    always_comb
    begin
        phase_next         = phase_reg;
        paused_next        = paused_reg;
        mode_next          = mode_reg;
        switched_next      = switched_reg;
        safety_next        = safety_reg;
        pending_abort_next = pending_abort_reg;
        elapsed_next       = elapsed_reg;
        status_next        = ST_OK;
        heater_off_next    = 1'b0;
        persist_next       = 1'b0;

        case (b.command)
            CMD_TICK:
            begin
                if (active && !paused_reg && elapsed_reg != ELAPSED_MAX)
                begin
                    elapsed_next = elapsed_reg + ELAPSED_BITS'(1);
                end
            end
            CMD_START:
            begin
                if (active)
                begin
                    status_next = ST_STATE;
                end
                else if (!mode_ok)
                begin
                    status_next = ST_ARG;
                end
                else
                begin
                    phase_next         = PH_PREHEAT;
                    paused_next        = 1'b0;
                    mode_next          = b.mode_in;
                    switched_next      = (b.mode_in == MODE_MANUAL);
                    safety_next        = SAFETY_OK;
                    pending_abort_next = 1'b0;
                    elapsed_next       = '0;
                    persist_next       = 1'b1;
                end
            end
            CMD_PAUSE:
            begin
                if (!active)
                begin
                    status_next = ST_STATE;
                end
                else if (!paused_reg)
                begin
                    paused_next  = 1'b1;
                    persist_next = 1'b1;
                end
            end
            CMD_RESUME:
            begin
                if (!paused_reg)
                begin
                    status_next = ST_STATE;
                end
                else
                begin
                    paused_next  = 1'b0;
                    persist_next = 1'b1;
                end
            end
            CMD_CHARGE:
            begin
                if (phase_reg != PH_PREHEAT)
                begin
                    status_next = ST_STATE;
                end
                else
                begin
                    phase_next   = PH_ROASTING;
                    elapsed_next = '0;
                    persist_next = 1'b1;
                end
            end
            CMD_COOL:
            begin
                if (!(phase_reg inside {PH_ROASTING, PH_DEVELOP}))
                begin
                    status_next = ST_STATE;
                end
                else
                begin
                    phase_next      = PH_COOLING;
                    heater_off_next = 1'b1;
                    persist_next    = 1'b1;
                end
            end
            CMD_CANCEL:
            begin
                if (!active)
                begin
                    status_next = ST_STATE;
                end
                else
                begin
                    pending_abort_next = 1'b1;
                    persist_next       = 1'b1;
                    // already cooling: only mark the abort
                    if (phase_reg != PH_COOLING)
                    begin
                        phase_next      = PH_COOLING;
                        heater_off_next = 1'b1;
                    end
                end
            end
            CMD_COMPLETE:
            begin
                if (phase_reg != PH_COOLING)
                begin
                    status_next = ST_STATE;
                end
                else
                begin
                    phase_next   = pending_abort_reg ? PH_ABORTED : PH_DONE;
                    persist_next = 1'b1;
                end
            end
            CMD_ABORT:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    status_next = ST_STATE;
                end
                else
                begin
                    phase_next      = PH_ABORTED;
                    heater_off_next = 1'b1;
                    persist_next    = 1'b1;
                end
            end
            CMD_MANUAL:
            begin
                if (mode_reg != MODE_PROFILE)
                begin
                    status_next = ST_STATE;
                end
                else if (!b.confirmed)
                begin
                    status_next = ST_ARG;
                end
                else
                begin
                    mode_next     = MODE_MANUAL;
                    switched_next = 1'b1;
                end
            end
            CMD_SAFETY:
            begin
                safety_next = b.safety_in;
            end
            CMD_RESTORE:
            begin
                if (b.restore_phase > PH_ABORTED || !mode_ok)
                begin
                    status_next = ST_ARG;
                end
                else
                begin
                    phase_next         = b.restore_phase;
                    paused_next        = b.restore_paused;
                    mode_next          = b.mode_in;
                    switched_next      = b.restore_switched;
                    safety_next        = SAFETY_OK;
                    pending_abort_next = 1'b0;
                    elapsed_next       = restore_sat;
                    persist_next       = 1'b1;
                end
            end
            CMD_QUERY:
            begin
            end
            default:
            begin
                status_next = ST_ARG;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            paused_reg        <= 1'b0;
            mode_reg          <= MODE_NONE;
            switched_reg      <= 1'b0;
            safety_reg        <= SAFETY_OK;
            pending_abort_reg <= 1'b0;
            elapsed_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg         <= phase_next;
                paused_reg        <= paused_next;
                mode_reg          <= mode_next;
                switched_reg      <= switched_next;
                safety_reg        <= safety_next;
                pending_abort_reg <= pending_abort_next;
                elapsed_reg       <= elapsed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg     <= status_next;
            heater_off_reg <= heater_off_next;
            persist_reg    <= persist_next;
        end
    end

    // state registers double as the result's state fields
    assign res.valid         = out_valid_reg;
    assign res.status        = status_reg;
    assign res.phase         = phase_reg;
    assign res.is_paused     = paused_reg;
    assign res.ctrl_mode     = mode_reg;
    assign res.switch_used   = switched_reg;
    assign res.safety_level  = safety_reg;
    assign res.abort_pending = pending_abort_reg;
    assign res.elapsed_count = elapsed_reg;
    assign res.heater_off    = heater_off_reg;
    assign res.persist       = persist_reg;

endmodule

>>> design/roast_session_sequencer_unit.sv
// Top level of the roast session sequencer.
// Depends on rss_pkg, rss_if, rss_in_stage and rss_core.
`timescale 1ns / 1ps

// Takes one command beat per cycle while results are taken, and returns
// exactly one result beat for each, in order: a status, the full session
// state after the command, and the heater-off and persist pulses. A command
// is captured by the input register when it is accepted; once the result
// register is empty or being taken, the session state update is written
// into the result register, and the result stays valid there until it is
// taken. The state update is a combinational decode with one
// ELAPSED_BITS-wide saturating increment, so throughput is one command per
// cycle while the result side keeps ready high; when the result is stalled,
// one more command is held in the input register.
module roast_session_sequencer_unit #(
    parameter int ELAPSED_BITS = 32
) (
    input logic       clk,
    input logic       rst_n,
    rss_cmd_if.sink   cmd,
    rss_res_if.source res
);
    import rss_pkg::*;

    stage_t stage;
    logic   take;

    rss_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .take  (take),
        .stage (stage)
    );

    rss_core #(
        .ELAPSED_BITS (ELAPSED_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .take  (take),
        .res   (res)
    );

endmodule

>>> sim/rss_session_checker.sv
// Result checker for the roast session sequencer testbench.
// Watches the command and result channels, keeps its own session state and
// compares every result beat. Depends on rss_pkg and rss_if.
`timescale 1ns / 1ps

module rss_session_checker #(
    parameter int ELAPSED_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    rss_cmd_if   cmd,
    rss_res_if   res,
    output int   errors,
    output int   pending,
    output int   checked
);
    import rss_pkg::*;

    localparam logic [63:0] ELAPSED_CAP = {64{1'b1}} >> (64 - ELAPSED_BITS);

    typedef struct packed {
        logic [1:0]              status;
        logic [2:0]              phase;
        logic                    paused;
        logic [1:0]              mode;
        logic                    switched;
        logic [1:0]              safety;
        logic                    abort_pend;
        logic [ELAPSED_BITS-1:0] elapsed;
        logic                    heater_off;
        logic                    persist;
    } session_view_t;

    logic [2:0]              cur_phase;
    logic                    cur_paused;
    logic [1:0]              cur_mode;
    logic                    cur_switched;
    logic [1:0]              cur_safety;
    logic                    cur_abort_pend;
    logic [ELAPSED_BITS-1:0] cur_elapsed;

    session_view_t expected_views[$];

    function automatic logic in_session(logic [2:0] p);
        return p >= PH_PREHEAT && p <= PH_COOLING;
    endfunction

    function automatic logic mode_ok(logic [1:0] m);
        return m == MODE_PROFILE || m == MODE_MANUAL;
    endfunction

    task automatic clear_session();
        cur_phase      = PH_IDLE;
        cur_paused     = 1'b0;
        cur_mode       = MODE_NONE;
        cur_switched   = 1'b0;
        cur_safety     = SAFETY_OK;
        cur_abort_pend = 1'b0;
        cur_elapsed    = '0;
    endtask

    // Updates the session state for one command and returns the beat the
    // block should answer with.
    task automatic apply_command(input cmd_t c, output session_view_t v);
        logic [1:0]  st;
        logic        heat;
        logic        save;
        logic [63:0] wide_elapsed;
        st   = ST_OK;
        heat = 1'b0;
        save = 1'b0;
        case (c.command)
            CMD_TICK:
                if (in_session(cur_phase) && !cur_paused &&
                    cur_elapsed != ELAPSED_CAP[ELAPSED_BITS-1:0])
                    cur_elapsed = cur_elapsed + ELAPSED_BITS'(1);
            CMD_START:
                if (in_session(cur_phase))
                    st = ST_STATE;
                else if (!mode_ok(c.mode_in))
                    st = ST_ARG;
                else
                begin
                    cur_phase      = PH_PREHEAT;
                    cur_paused     = 1'b0;
                    cur_mode       = c.mode_in;
                    cur_switched   = (c.mode_in == MODE_MANUAL);
                    cur_safety     = SAFETY_OK;
                    cur_abort_pend = 1'b0;
                    cur_elapsed    = '0;
                    save           = 1'b1;
                end
            CMD_PAUSE:
                if (!in_session(cur_phase))
                    st = ST_STATE;
                else if (!cur_paused)
                begin
                    cur_paused = 1'b1;
                    save       = 1'b1;
                end
            CMD_RESUME:
                if (!cur_paused)
                    st = ST_STATE;
                else
                begin
                    cur_paused = 1'b0;
                    save       = 1'b1;
                end
            CMD_CHARGE:
                if (cur_phase != PH_PREHEAT)
                    st = ST_STATE;
                else
                begin
                    cur_phase   = PH_ROASTING;
                    cur_elapsed = '0;
                    save        = 1'b1;
                end
            CMD_COOL:
                if (cur_phase != PH_ROASTING && cur_phase != PH_DEVELOP)
                    st = ST_STATE;
                else
                begin
                    cur_phase = PH_COOLING;
                    heat      = 1'b1;
                    save      = 1'b1;
                end
            CMD_CANCEL:
                if (!in_session(cur_phase))
                    st = ST_STATE;
                else
                begin
                    cur_abort_pend = 1'b1;
                    // already cooling: heater is off, only flag the abort
                    if (cur_phase != PH_COOLING)
                    begin
                        cur_phase = PH_COOLING;
                        heat      = 1'b1;
                    end
                    save = 1'b1;
                end
            CMD_COMPLETE:
                if (cur_phase != PH_COOLING)
                    st = ST_STATE;
                else
                begin
                    cur_phase = cur_abort_pend ? PH_ABORTED : PH_DONE;
                    save      = 1'b1;
                end
            CMD_ABORT:
                if (cur_phase == PH_IDLE)
                    st = ST_STATE;
                else
                begin
                    cur_phase = PH_ABORTED;
                    heat      = 1'b1;
                    save      = 1'b1;
                end
            CMD_MANUAL:
                if (cur_mode != MODE_PROFILE)
                    st = ST_STATE;
                else if (!c.confirmed)
                    st = ST_ARG;
                else
                begin
                    cur_mode     = MODE_MANUAL;
                    cur_switched = 1'b1;
                end
            CMD_SAFETY:
                cur_safety = c.safety_in;
            CMD_RESTORE:
                if (c.restore_phase > PH_ABORTED || !mode_ok(c.mode_in))
                    st = ST_ARG;
                else
                begin
                    wide_elapsed   = 64'(c.restore_elapsed);
                    cur_phase      = c.restore_phase;
                    cur_paused     = c.restore_paused;
                    cur_mode       = c.mode_in;
                    cur_switched   = c.restore_switched;
                    cur_safety     = SAFETY_OK;
                    cur_abort_pend = 1'b0;
                    cur_elapsed    = (wide_elapsed > ELAPSED_CAP) ?
                                     ELAPSED_CAP[ELAPSED_BITS-1:0] :
                                     wide_elapsed[ELAPSED_BITS-1:0];
                    save           = 1'b1;
                end
            CMD_QUERY:
                ;
            default:
                st = ST_ARG;
        endcase
        v.status     = st;
        v.phase      = cur_phase;
        v.paused     = cur_paused;
        v.mode       = cur_mode;
        v.switched   = cur_switched;
        v.safety     = cur_safety;
        v.abort_pend = cur_abort_pend;
        v.elapsed    = cur_elapsed;
        v.heater_off = heat;
        v.persist    = save;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cmd_t          beat;
        session_view_t want;
        if (!rst_n)
        begin
            clear_session();
            expected_views.delete();
            pending = 0;
        end
        else
        begin
            // results first, so a beat accepted this edge cannot match itself
            if (res.valid && res.ready)
            begin
                if (expected_views.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with no command outstanding, %s %0d phase %0d",
                             $time, "expected none, actual status", res.status, res.phase);
                end
                else
                begin
                    want = expected_views.pop_front();
                    check_field("status", 64'(want.status), 64'(res.status));
                    check_field("phase", 64'(want.phase), 64'(res.phase));
                    check_field("is_paused", 64'(want.paused), 64'(res.is_paused));
                    check_field("ctrl_mode", 64'(want.mode), 64'(res.ctrl_mode));
                    check_field("switch_used", 64'(want.switched), 64'(res.switch_used));
                    check_field("safety_level", 64'(want.safety), 64'(res.safety_level));
                    check_field("abort_pending", 64'(want.abort_pend),
                                64'(res.abort_pending));
                    check_field("elapsed_count", 64'(want.elapsed), 64'(res.elapsed_count));
                    check_field("heater_off", 64'(want.heater_off), 64'(res.heater_off));
                    check_field("persist", 64'(want.persist), 64'(res.persist));
                    checked++;
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                beat = {cmd.command, cmd.mode_in, cmd.confirmed, cmd.safety_in,
                        cmd.restore_phase, cmd.restore_paused, cmd.restore_switched,
                        cmd.restore_elapsed};
                apply_command(beat, want);
                expected_views.push_back(want);
            end
            pending = expected_views.size();
        end
    end

endmodule

>>> sim/tb_roast_session_sequencer_unit.sv
// Testbench top for roast_session_sequencer_unit: clock, reset, command
// stimulus, result back-pressure and the verdict. Checking is done by
// rss_session_checker; depends on rss_pkg, rss_if and the block.
`timescale 1ns / 1ps

module tb_roast_session_sequencer_unit;
    import rss_pkg::*;

    localparam int         EB             = 32;
    localparam int         ITEM_TARGET    = 1350;
    localparam int         CALM_TAIL      = 200;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam logic [3:0] CMD_UNUSED     = 4'd15;
    localparam logic [1:0] MODE_BAD       = 2'd3;
    localparam logic [2:0] PHASE_BAD      = 3'd7;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   sent_count;
    int   session_count;
    int   noise_count;
    int   quiet_cycles;
    int   fail_count;
    int   pending_count;
    int   checked_count;

    rss_cmd_if               cmd_ch ();
    rss_res_if #(.ELAPSED_BITS(EB)) res_ch ();

    roast_session_sequencer_unit #(
        .ELAPSED_BITS(EB)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    rss_session_checker #(
        .ELAPSED_BITS(EB)
    ) u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .errors  (fail_count),
        .pending (pending_count),
        .checked (checked_count)
    );

    initial
        clk = 1'b0;

    always #10 clk = ~clk;

    function automatic cmd_t plain_cmd(logic [3:0] op);
        cmd_t c;
        c         = '0;
        c.command = op;
        return c;
    endfunction

    // every field but the command random; restore_elapsed sometimes right at the top
    function automatic cmd_t random_cmd(logic [3:0] op);
        cmd_t c;
        c.command          = op;
        c.mode_in          = 2'($urandom);
        c.confirmed        = 1'($urandom);
        c.safety_in        = 2'($urandom);
        c.restore_phase    = 3'($urandom);
        c.restore_paused   = 1'($urandom);
        c.restore_switched = 1'($urandom);
        c.restore_elapsed  = $urandom;
        if ($urandom_range(0, 7) == 0)
            c.restore_elapsed = 32'hFFFF_FFFF - $urandom_range(0, 3);
        return c;
    endfunction

    task automatic send(input cmd_t c);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        cmd_ch.valid            <= 1'b1;
        cmd_ch.command          <= c.command;
        cmd_ch.mode_in          <= c.mode_in;
        cmd_ch.confirmed        <= c.confirmed;
        cmd_ch.safety_in        <= c.safety_in;
        cmd_ch.restore_phase    <= c.restore_phase;
        cmd_ch.restore_paused   <= c.restore_paused;
        cmd_ch.restore_switched <= c.restore_switched;
        cmd_ch.restore_elapsed  <= c.restore_elapsed;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sent_count++;
    endtask

    // mostly ticks, with the operator poking at the session in between
    task automatic session_traffic(input int n);
        int   i;
        cmd_t c;
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 12))
                7:       c = random_cmd(CMD_PAUSE);
                8:       c = random_cmd(CMD_RESUME);
                9:       c = random_cmd(CMD_QUERY);
                10:      c = random_cmd(CMD_SAFETY);
                11:      c = random_cmd(CMD_MANUAL);
                default: c = random_cmd(CMD_TICK);
            endcase
            send(c);
        end
    endtask

    task automatic run_session();
        cmd_t c;
        session_count++;
        c         = random_cmd(CMD_START);
        c.mode_in = 2'($urandom_range(MODE_PROFILE, MODE_MANUAL));
        if ($urandom_range(0, 5) == 0)
        begin
            // pick up after a power loss somewhere inside a session
            c               = random_cmd(CMD_RESTORE);
            c.mode_in       = 2'($urandom_range(MODE_PROFILE, MODE_MANUAL));
            c.restore_phase = 3'($urandom_range(PH_PREHEAT, PH_COOLING));
            if ($urandom_range(0, 1) == 0)
                c.restore_elapsed = 32'hFFFF_FFFF - $urandom_range(0, 6);
        end
        send(c);
        session_traffic($urandom_range(0, 8));
        send(random_cmd(CMD_CHARGE));
        session_traffic($urandom_range(1, 12));
        case ($urandom_range(0, 9))
            0:       send(random_cmd(CMD_ABORT));
            1, 2:    send(random_cmd(CMD_CANCEL));
            default: send(random_cmd(CMD_COOL));
        endcase
        session_traffic($urandom_range(0, 6));
        if ($urandom_range(0, 3) == 0)
            send(random_cmd(CMD_CANCEL));
        send(random_cmd(CMD_COMPLETE));
        if ($urandom_range(0, 4) == 0)
            send(random_cmd(CMD_ABORT));
    endtask

    task automatic run_noise(input int n);
        int i;
        noise_count++;
        for (i = 0; i < n; i++)
            send(random_cmd(4'($urandom_range(0, 15))));
    endtask

    initial
    begin
        cmd_t c;
        idle_on                 = 1'b1;
        sent_count              = 0;
        session_count           = 0;
        noise_count             = 0;
        rst_n                   = 1'b0;
        cmd_ch.valid            = 1'b0;
        cmd_ch.command          = CMD_QUERY;
        cmd_ch.mode_in          = MODE_NONE;
        cmd_ch.confirmed        = 1'b0;
        cmd_ch.safety_in        = SAFETY_OK;
        cmd_ch.restore_phase    = PH_IDLE;
        cmd_ch.restore_paused   = 1'b0;
        cmd_ch.restore_switched = 1'b0;
        cmd_ch.restore_elapsed  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: a query and rejected commands from idle, then a hand-driven session and restores
        send(plain_cmd(CMD_QUERY));
        send(plain_cmd(CMD_PAUSE));
        send(plain_cmd(CMD_RESUME));
        send(plain_cmd(CMD_MANUAL));
        send(plain_cmd(CMD_UNUSED));
        c         = plain_cmd(CMD_START);
        c.mode_in = MODE_BAD;
        send(c);
        c.mode_in = MODE_PROFILE;
        send(c);
        send(c);                        // start while already running
        send(plain_cmd(CMD_TICK));
        send(plain_cmd(CMD_PAUSE));
        send(plain_cmd(CMD_PAUSE));     // second pause is a quiet no-op
        send(plain_cmd(CMD_CHARGE));    // charge while paused keeps the pause
        send(plain_cmd(CMD_TICK));
        send(plain_cmd(CMD_RESUME));
        send(plain_cmd(CMD_MANUAL));    // not confirmed
        c           = plain_cmd(CMD_MANUAL);
        c.confirmed = 1'b1;
        send(c);
        c           = plain_cmd(CMD_SAFETY);
        c.safety_in = '1;
        send(c);
        send(plain_cmd(CMD_COOL));
        send(plain_cmd(CMD_CANCEL));    // cancel during cooling: no heater pulse
        send(plain_cmd(CMD_COMPLETE));  // ends aborted
        send(plain_cmd(CMD_ABORT));     // abort again from aborted
        c               = plain_cmd(CMD_RESTORE);
        c.mode_in       = MODE_MANUAL;
        c.restore_phase = PHASE_BAD;
        send(c);
        c.restore_phase = PH_COOLING;
        c.mode_in       = MODE_NONE;
        send(c);
        c.mode_in          = MODE_PROFILE;
        c.restore_switched = 1'b1;
        c.restore_elapsed  = '1;
        send(c);
        send(plain_cmd(CMD_TICK));      // counter pinned at the top
        send(plain_cmd(CMD_ABORT));

        while (sent_count < ITEM_TARGET)
        begin
            if (ITEM_TARGET - sent_count <= CALM_TAIL)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) < 7)
                run_session();
            else
                run_noise($urandom_range(5, 20));
        end
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (4) @(posedge clk);

        $display("Sent %0d commands: 26 directed, %0d session sequences, %0d noise bursts.",
                 sent_count, session_count, noise_count);
        $display("Compared %0d result beats against the predicted session state.",
                 checked_count);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 9) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat moved for %0d cycles at %0t", quiet_cycles, $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
